// ----- rtl/stepper_linear_ramp_scheduler_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stepper ramp scheduler.
// Each macro is empty when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef STEPPER_LINEAR_RAMP_SCHEDULER_UNIT_DEFINES_SVH
`define STEPPER_LINEAR_RAMP_SCHEDULER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SLRS_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("slrs check failed");
`define SLRS_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("slrs check failed");
`else
`define SLRS_ASSERT_IMP(lbl, clk, rstn, a, c)
`define SLRS_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ----- rtl/slrs_pkg.sv -----
// ----------------------------------------------------------------------------
// slrs_pkg
// Shared constants and types of the stepper ramp scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package slrs_pkg;
    localparam logic [15:0] IDLE_INTERVAL = 16'd65500;
    localparam logic [16:0] NO_MIN        = 17'h1FFFF;
    localparam logic [23:0] MASK24        = 24'hFFFFFF;
    localparam logic [15:0] START_RESET   = 16'd5000;
    localparam logic [15:0] MIN_RESET     = 16'd1;
    localparam logic        REQ_START     = 1'b0;
    localparam logic        REQ_EXPIRY    = 1'b1;
    localparam logic        REG_START     = 1'b0;
    localparam logic        REG_MIN       = 1'b1;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage

// ----- rtl/slrs_divider.sv -----
// ----------------------------------------------------------------------------
// slrs_divider
// Restoring divider, one quotient bit a cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stepper_linear_ramp_scheduler_unit_defines.svh"
module slrs_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  slrs_pkg::div_req_t req,
    output slrs_pkg::div_rsp_t rsp
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] sub;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[63]};
        sub       = trial - {1'b0, dvs_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!sub[32]) begin
                rem_next = sub;
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `SLRS_ASSERT_NXT(a_div_done_ends, aclk, aresetn, done_reg, !busy_reg)
    `SLRS_ASSERT_IMP(a_div_cnt_live, aclk, aresetn, busy_reg, cnt_reg != 7'd0)
    `SLRS_ASSERT_NXT(a_div_start, aclk, aresetn, req.start, busy_reg)
endmodule

// ----- rtl/stepper_linear_ramp_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// stepper_linear_ramp_scheduler_unit
// Linear acceleration ramp scheduler for several stepper motors.
// ----------------------------------------------------------------------------
// Channel   | Direction | Contents
// s_axis    | in        | req_type on tuser; motor and steps on tdata
// m_axis    | out       | step, done and active masks, direction, interval, position
// APB       | in/out    | start_interval (0x0), min_interval (0x4)
//
// A start word loads the motor, then makes two passes over the motors, one for
// the smallest remaining time and one for the due set, and then registers the
// result word. An expiry word, when any motor runs, first finds the elapsed
// time in one pass and then visits each motor: a motor that is not due is passed
// over, one whose interval holds is finished at once, and one in acceleration
// or deceleration waits for one pass of the shared divider, deceleration after
// a multiply. The same two scans and the output word follow. The input is not
// ready while a word is in work or while a result waits; reset clears all motor
// state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stepper_linear_ramp_scheduler_unit_defines.svh"
module stepper_linear_ramp_scheduler_unit #(
    parameter int MOTORS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [1:0] motor, [25:2] steps
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] step_mask, [4] dir_valid, [5] dir_level, [21:6] next_interval,
    // [25:22] active_mask, [29:26] done_mask, [61:30] position
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_VISIT = 4'd2;
    localparam logic [3:0] ST_RAMP  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_DIVW  = 4'd5;
    localparam logic [3:0] ST_FIN   = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_SCAN2 = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_MIN0  = 4'd10;
    localparam logic [3:0] ST_DIVS  = 4'd11;

    // Configuration.
    logic [15:0] start_iv_reg, min_iv_reg;
    logic        wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_iv_reg <= slrs_pkg::START_RESET;
            min_iv_reg   <= slrs_pkg::MIN_RESET;
        end else if (wr_en && paddr[2] == slrs_pkg::REG_START && paddr[1:0] == 2'b00) begin
            start_iv_reg <= pwdata[15:0];
        end else if (wr_en && paddr[2] == slrs_pkg::REG_MIN && paddr[1:0] == 2'b00) begin
            min_iv_reg <= pwdata[15:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == 3'd0) prdata = {16'd0, start_iv_reg};
        else if (paddr == 3'd4) prdata = {16'd0, min_iv_reg};
    end

    // Per-motor state.
    logic [31:0] ifx_reg [MOTORS];
    logic [15:0] tl_reg  [MOTORS];
    logic [23:0] ri_reg  [MOTORS];
    logic [23:0] sd_reg  [MOTORS];
    logic [23:0] st_reg  [MOTORS];
    logic [23:0] ru_reg  [MOTORS];
    logic [31:0] pos_reg [MOTORS];
    logic        neg_reg [MOTORS];
    logic [MOTORS-1:0] run_reg, due_reg;

    logic [3:0]  state_reg;
    logic [MW-1:0] idx_reg;
    logic [1:0]  mot_reg;
    logic [23:0] stp_reg;
    logic [16:0] mind_reg;
    logic [15:0] elap_reg;
    logic [3:0]  smask_reg, dmask_reg;
    logic        dv_reg, dl_reg;
    logic [63:0] d_reg;
    logic [33:0] fac_reg;
    logic        decel_reg;
    logic [63:0] out_reg;
    logic        outv_reg;

    slrs_pkg::div_req_t dreq;
    slrs_pkg::div_rsp_t drsp;
    slrs_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic        acc;
    logic        last_idx;
    logic        mot_ok;
    logic [23:0] mag;
    logic        sneg;
    logic [23:0] ri_inc;
    logic [25:0] n4;
    logic [63:0] dnew;
    logic [47:0] minfx;
    logic [23:0] thr;
    logic [15:0] tl_sat;
    logic [31:0] d32;
    logic [15:0] next_iv;

    assign acc      = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata  = out_reg;
    assign last_idx = (32'(idx_reg) == MOTORS - 1);
    assign mot_ok   = (32'(mot_reg) < MOTORS);
    assign sneg     = stp_reg[23];
    assign mag      = sneg ? ((stp_reg == 24'h800000) ? 24'h800000 : (24'd0 - stp_reg))
                           : stp_reg;
    assign ri_inc   = (ri_reg[idx_reg] < slrs_pkg::MASK24) ? ri_reg[idx_reg] + 24'd1
                                                          : ri_reg[idx_reg];
    assign n4       = {ri_reg[idx_reg], 2'b00};
    assign minfx    = {min_iv_reg, 16'd0};
    assign thr      = (ru_reg[idx_reg] > st_reg[idx_reg]) ? 24'd0
                                                          : st_reg[idx_reg] - ru_reg[idx_reg];
    assign d32      = (dnew > 64'hFFFFFFFF) ? 32'hFFFFFFFF : dnew[31:0];
    assign tl_sat   = d32[31:16];
    assign next_iv  = (run_reg == '0) ? slrs_pkg::IDLE_INTERVAL : mind_reg[15:0];

    // Result of the division in the ramp step.
    always_comb begin
        if (decel_reg) dnew = drsp.quotient;
        else           dnew = d_reg - drsp.quotient;
    end

    always_comb begin
        dreq.start    = 1'b0;
        dreq.dividend = d_reg;
        dreq.divisor  = '0;
        if (state_reg == ST_RAMP && ru_reg[idx_reg] == 24'd0) begin
            dreq.start    = 1'b1;
            dreq.dividend = {31'd0, ifx_reg[idx_reg], 1'b0};
            dreq.divisor  = {6'd0, ri_inc, 2'b01};
        end else if (state_reg == ST_DIVS) begin
            dreq.start    = 1'b1;
            dreq.divisor  = {6'd0, n4} - 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            outv_reg  <= 1'b0;
            run_reg   <= '0;
            due_reg   <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < MOTORS; i++) begin
                ifx_reg[i] <= '0; tl_reg[i] <= '0; ri_reg[i] <= '0; sd_reg[i] <= '0;
                st_reg[i]  <= '0; ru_reg[i] <= '0; pos_reg[i] <= '0; neg_reg[i] <= 1'b0;
            end
        end else begin
            if (outv_reg && m_tready) outv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        mot_reg   <= s_tdata[1:0];
                        stp_reg   <= s_tdata[25:2];
                        smask_reg <= '0;
                        dmask_reg <= '0;
                        dv_reg    <= 1'b0;
                        dl_reg    <= 1'b0;
                        idx_reg   <= '0;
                        mind_reg  <= slrs_pkg::NO_MIN;
                        if (s_tuser == slrs_pkg::REQ_START) state_reg <= ST_START;
                        else if (run_reg != '0) state_reg <= ST_MIN0;
                        else state_reg <= ST_SCAN;
                    end
                end
                ST_START: begin
                    if (mot_ok) begin
                        dv_reg <= 1'b1;
                        dl_reg <= sneg;
                        neg_reg[mot_reg[MW-1:0]] <= sneg || (stp_reg == 24'd0);
                        st_reg[mot_reg[MW-1:0]]  <= mag;
                        ifx_reg[mot_reg[MW-1:0]] <= {start_iv_reg, 16'd0};
                        tl_reg[mot_reg[MW-1:0]]  <= start_iv_reg;
                        sd_reg[mot_reg[MW-1:0]]  <= '0;
                        ri_reg[mot_reg[MW-1:0]]  <= '0;
                        ru_reg[mot_reg[MW-1:0]]  <= '0;
                        if (mag == 24'd0) begin
                            run_reg[mot_reg[MW-1:0]]   <= 1'b0;
                            dmask_reg[mot_reg[MW-1:0]] <= 1'b1;
                        end else begin
                            run_reg[mot_reg[MW-1:0]] <= 1'b1;
                        end
                    end
                    state_reg <= ST_SCAN;
                end
                ST_MIN0: begin
                    // Elapsed time is the smallest remaining time, one motor a cycle.
                    if (run_reg[idx_reg] && {1'b0, tl_reg[idx_reg]} < mind_reg)
                        mind_reg <= {1'b0, tl_reg[idx_reg]};
                    if (last_idx) begin
                        idx_reg   <= '0;
                        state_reg <= ST_VISIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    elap_reg <= (run_reg[idx_reg] && {1'b0, tl_reg[idx_reg]} < mind_reg)
                                ? tl_reg[idx_reg] : mind_reg[15:0];
                end
                ST_VISIT: begin
                    if (run_reg[idx_reg] && !due_reg[idx_reg]) begin
                        tl_reg[idx_reg] <= (tl_reg[idx_reg] > elap_reg)
                                           ? tl_reg[idx_reg] - elap_reg : 16'd0;
                    end
                    if (run_reg[idx_reg] && due_reg[idx_reg]) begin
                        if (sd_reg[idx_reg] < st_reg[idx_reg]) begin
                            smask_reg[idx_reg] <= 1'b1;
                            sd_reg[idx_reg]    <= sd_reg[idx_reg] + 24'd1;
                            pos_reg[idx_reg]   <= pos_reg[idx_reg]
                                                  + (neg_reg[idx_reg] ? 32'hFFFFFFFF : 32'd1);
                            if (sd_reg[idx_reg] + 24'd1 >= st_reg[idx_reg]) begin
                                dmask_reg[idx_reg] <= 1'b1;
                                run_reg[idx_reg]   <= 1'b0;
                            end
                        end
                        state_reg <= ST_RAMP;
                    end else if (last_idx) begin
                        idx_reg   <= '0;
                        mind_reg  <= slrs_pkg::NO_MIN;
                        state_reg <= ST_SCAN;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_RAMP: begin
                    if (ru_reg[idx_reg] == 24'd0) begin
                        d_reg <= {32'd0, ifx_reg[idx_reg]};
                        ri_reg[idx_reg] <= ri_inc;
                        decel_reg <= 1'b0;
                        state_reg <= ST_DIVW;
                    end else if (sd_reg[idx_reg] >= thr && ri_reg[idx_reg] != 24'd0) begin
                        d_reg     <= {32'd0, ifx_reg[idx_reg]};
                        decel_reg <= 1'b1;
                        fac_reg   <= {8'd0, n4} + 34'd1;
                        state_reg <= ST_MUL;
                    end else begin
                        tl_reg[idx_reg] <= ifx_reg[idx_reg][31:16];
                        state_reg <= ST_FIN;
                    end
                end
                ST_MUL: begin
                    // Interval times (4n+1); the divider starts on it in the next cycle.
                    d_reg     <= {32'd0, d_reg[31:0]} * {32'd0, fac_reg[31:0]};
                    state_reg <= ST_DIVS;
                end
                ST_DIVS: begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (drsp.done) begin
                        if (!decel_reg) begin
                            if (dnew <= {16'd0, minfx}) begin
                                ifx_reg[idx_reg] <= {min_iv_reg, 16'd0};
                                tl_reg[idx_reg]  <= min_iv_reg;
                            end else begin
                                ifx_reg[idx_reg] <= dnew[31:0];
                                tl_reg[idx_reg]  <= dnew[31:16];
                            end
                            // The ramp ends at the cruise limit or at half the move.
                            if (dnew <= {16'd0, minfx}
                                || sd_reg[idx_reg] >= {1'b0, st_reg[idx_reg][23:1]})
                                ru_reg[idx_reg] <= sd_reg[idx_reg];
                        end else begin
                            ifx_reg[idx_reg] <= d32;
                            tl_reg[idx_reg]  <= tl_sat;
                            ri_reg[idx_reg]  <= ri_reg[idx_reg] - 24'd1;
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (last_idx) begin
                        idx_reg   <= '0;
                        mind_reg  <= slrs_pkg::NO_MIN;
                        state_reg <= ST_SCAN;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_VISIT;
                    end
                end
                ST_SCAN: begin
                    if (run_reg[idx_reg] && {1'b0, tl_reg[idx_reg]} < mind_reg)
                        mind_reg <= {1'b0, tl_reg[idx_reg]};
                    if (last_idx) begin
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN2;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SCAN2: begin
                    due_reg[idx_reg] <= run_reg[idx_reg]
                                        && ({1'b0, tl_reg[idx_reg]} == mind_reg);
                    if (last_idx) begin
                        idx_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    out_reg <= {2'b00,
                                mot_ok ? pos_reg[mot_reg[MW-1:0]] : 32'd0,
                                dmask_reg, 4'(run_reg), next_iv, dl_reg, dv_reg, smask_reg};
                    outv_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SLRS_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, state_reg == ST_IDLE)
    `SLRS_ASSERT_IMP(a_no_in_while_out, aclk, aresetn, outv_reg, !s_tready)
    `SLRS_ASSERT_NXT(a_out_after, aclk, aresetn, state_reg == ST_OUT, outv_reg)
endmodule
